>>> rtl/dtmf_pkg.sv
// Package with the types, constants and tables of the DTMF tone generator.
package dtmf_pkg;

   localparam int unsigned SAMPLE_RATE_HZ   = 8000;
   localparam int unsigned SINE_TABLE_DEPTH = 256;

   // Address width of the quarter-wave table, which holds SINE_TABLE_DEPTH + 1 entries.
   localparam int unsigned TABLE_ADDR_W = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int unsigned TABLE_PROD_W = 30 + TABLE_ADDR_W;

   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic {
      OP_START = 1'b0,
      OP_NEXT  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BAD_KEY = 2'd1,
      STATUS_IDLE    = 2'd2
   } status_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] key;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] sample;
      status_type         status;
      logic               last;
   } rsp_word_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] row;
      logic [1:0] col;
   } key_decode_type;

   typedef logic [SINE_TABLE_DEPTH:0][14:0] quarter_table_type;

   // Phase increment per sample for a tone of hz, rounded to nearest.
   function automatic logic [31:0] phase_step(input logic [31:0] hz);
      logic [63:0] num;
      num = ({32'd0, hz} << 32) + 64'(SAMPLE_RATE_HZ / 2);
      num = num / 64'(SAMPLE_RATE_HZ);
      return num[31:0];
   endfunction

   // Quarter-wave sine table, built at elaboration by a truncated Horner series in Q30.
   function automatic quarter_table_type build_quarter_table();
      quarter_table_type tbl;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] d;
      logic [63:0] s;
      logic [63:0] v;
      tbl = '0;
      for (int k = 0; k <= int'(SINE_TABLE_DEPTH); k++) begin
         x  = (64'(k) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
         x2 = (x * x) >> 30;
         t  = Q30_ONE;
         d  = ((x2 * t) >> 30) / 64'd110;
         t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
         d  = ((x2 * t) >> 30) / 64'd72;
         t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
         d  = ((x2 * t) >> 30) / 64'd42;
         t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
         d  = ((x2 * t) >> 30) / 64'd20;
         t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
         d  = ((x2 * t) >> 30) / 64'd6;
         t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
         s  = (x * t) >> 30;
         v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
         if (v > 64'd32767) begin
            v = 64'd32767;
         end
         tbl[k] = v[14:0];
      end
      return tbl;
   endfunction

   localparam quarter_table_type QUARTER_TABLE = build_quarter_table();

   localparam logic [31:0] ROW_STEP [4] = '{phase_step(32'd697),  phase_step(32'd770),
                                           phase_step(32'd852),  phase_step(32'd941)};
   localparam logic [31:0] COL_STEP [4] = '{phase_step(32'd1209), phase_step(32'd1336),
                                           phase_step(32'd1477), phase_step(32'd1633)};

   // Keypad layout: position bits [3:2] pick the row tone, bits [1:0] the column tone.
   localparam logic [7:0] KEYPAD [16] = '{"1", "2", "3", "A", "4", "5", "6", "B",
                                          "7", "8", "9", "C", "*", "0", "#", "D"};

   function automatic key_decode_type decode_key(input logic [7:0] key);
      key_decode_type dec;
      logic [3:0] pos;
      dec = '0;
      for (int i = 0; i < 16; i++) begin
         if (key == KEYPAD[i]) begin
            pos       = 4'(i);
            dec.valid = 1'b1;
            dec.row   = pos[3:2];
            dec.col   = pos[1:0];
         end
      end
      return dec;
   endfunction

   // Full-wave sine from the quarter table: mirror in odd quadrants, negate in the lower half.
   function automatic logic signed [15:0] sine_lookup(input logic [31:0] phase);
      logic [TABLE_PROD_W-1:0] prod;
      logic [TABLE_ADDR_W-1:0] idx;
      logic [TABLE_ADDR_W-1:0] addr;
      logic [15:0]             mag;
      prod = TABLE_PROD_W'(phase[29:0]) * TABLE_PROD_W'(SINE_TABLE_DEPTH);
      idx  = prod[TABLE_PROD_W-1:30];
      addr = phase[30] ? TABLE_ADDR_W'(SINE_TABLE_DEPTH) - idx : idx;
      mag  = {1'b0, QUARTER_TABLE[addr]};
      return phase[31] ? -$signed(mag) : $signed(mag);
   endfunction

endpackage

>>> rtl/dtmf_tone_generator_core.sv
// Top level of the DTMF tone generator: key decode, two phase accumulators and sample output.
//
//   channel | ports                        | direction | word
//   --------+------------------------------+-----------+-------------------------------
//   request | req_valid req_stall req_word | in        | op, key
//   result  | rsp_valid rsp_stall rsp_word | out       | sample, status, last
//   csr     | csr_wr_en csr_wr_data        | in        | tone_length, written directly
//
// Each request word gives exactly one result word, registered in the output register or
// the skid register; a new word is accepted in every cycle that req_stall is low; the phase
// accumulator update and the two table lookups form the single stage before them.
// Reset is synchronous and leaves the block idle with tone_length at 800.
// A result that is stalled moves into a one-word skid register, so the block still takes
// one more request; req_stall rises only while that skid register is occupied.
module dtmf_tone_generator_core
   import dtmf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data
);

   // Tone state.
   logic [31:0]  row_phase_ff, row_phase_in;
   logic [31:0]  col_phase_ff, col_phase_in;
   logic [1:0]   row_select_ff, row_select_in;
   logic [1:0]   col_select_ff, col_select_in;
   logic [15:0]  sample_index_ff, sample_index_in;
   logic         active_ff, active_in;
   logic [15:0]  tone_length_ff, tone_length_in;

   // Output register and skid register.
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type skid_word_ff, skid_word_in;

   logic               accept;
   logic               out_take;
   logic               is_start;
   logic               emit;
   key_decode_type     dec;
   logic [1:0]         row_sel_use;
   logic [1:0]         col_sel_use;
   logic [31:0]        row_phase_use;
   logic [31:0]        col_phase_use;
   logic [15:0]        index_next;
   logic               last;
   logic signed [15:0] row_sine;
   logic signed [15:0] col_sine;
   logic signed [16:0] sine_sum;
   rsp_word_type       result;

   assign accept   = req_valid && !skid_valid_ff;
   assign out_take = rsp_valid_ff && !rsp_stall;

   assign req_stall = skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // A start word restarts the tone from phase zero with the decoded key; a next word
   // continues the current tone.
   always_comb begin
      dec           = decode_key(req_word.key);
      is_start      = (req_word.op == OP_START);
      emit          = is_start ? dec.valid : active_ff;
      row_sel_use   = is_start ? dec.row : row_select_ff;
      col_sel_use   = is_start ? dec.col : col_select_ff;
      row_phase_use = is_start ? 32'd0 : row_phase_ff;
      col_phase_use = is_start ? 32'd0 : col_phase_ff;
      index_next    = (is_start ? 16'd0 : sample_index_ff) + 16'd1;
      last          = (index_next >= tone_length_ff);
      row_sine      = sine_lookup(row_phase_use);
      col_sine      = sine_lookup(col_phase_use);
      // The arithmetic halving is a floor, which keeps the result within one Q1.15 word.
      sine_sum      = {row_sine[15], row_sine} + {col_sine[15], col_sine};
      if (emit) begin
         result.sample = sine_sum[16:1];
         result.status = STATUS_OK;
         result.last   = last;
      end else begin
         result.sample = 16'sd0;
         result.status = is_start ? STATUS_BAD_KEY : STATUS_IDLE;
         result.last   = 1'b0;
      end
   end

   // Tone state update. A bad key and a next word while idle leave the state alone.
   always_comb begin
      row_phase_in    = row_phase_ff;
      col_phase_in    = col_phase_ff;
      row_select_in   = row_select_ff;
      col_select_in   = col_select_ff;
      sample_index_in = sample_index_ff;
      active_in       = active_ff;
      tone_length_in  = csr_wr_en ? csr_wr_data : tone_length_ff;
      if (accept && emit) begin
         row_phase_in    = row_phase_use + ROW_STEP[row_sel_use];
         col_phase_in    = col_phase_use + COL_STEP[col_sel_use];
         row_select_in   = row_sel_use;
         col_select_in   = col_sel_use;
         sample_index_in = index_next;
         active_in       = !last;
      end
   end

   // Output register with a skid register behind it. Order is kept because a new result
   // only lands in the skid register while the output register holds an older one.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_word_in   = rsp_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            rsp_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!rsp_valid_ff || out_take) begin
            rsp_valid_in = 1'b1;
            rsp_word_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_word_in  = result;
         end
      end else if (out_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_phase_ff    <= 32'd0;
         col_phase_ff    <= 32'd0;
         row_select_ff   <= 2'd0;
         col_select_ff   <= 2'd0;
         sample_index_ff <= 16'd0;
         active_ff       <= 1'b0;
         tone_length_ff  <= 16'd800;
         rsp_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         row_phase_ff    <= row_phase_in;
         col_phase_ff    <= col_phase_in;
         row_select_ff   <= row_select_in;
         col_select_ff   <= col_select_in;
         sample_index_ff <= sample_index_in;
         active_ff       <= active_in;
         tone_length_ff  <= tone_length_in;
         rsp_valid_ff    <= rsp_valid_in;
         skid_valid_ff   <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff  <= rsp_word_in;
      skid_word_ff <= skid_word_in;
   end

endmodule

>>> tb/dtmf_tone_generator_core_test.sv
// Self-checking testbench of the DTMF tone generator core: key sweep, lengths, random traffic.
module dtmf_tone_generator_core_test;
   import dtmf_pkg::*;

   // Run limits. The cycle limit leaves a wide margin over the slowest correct run.
   localparam int CYCLE_LIMIT   = 500000;
   localparam int HOLD_CYCLES   = 400;
   localparam int MAX_PRINTED   = 40;
   localparam int CHUNK_WORDS   = 100;
   localparam int DEPTH         = int'(SINE_TABLE_DEPTH);
   localparam int RATE          = int'(SAMPLE_RATE_HZ);

   // Tone frequencies in Hz and the keypad layout: the key position bits [3:2]
   // select the row tone and bits [1:0] the column tone.
   localparam int unsigned ROW_HZ [4]     = '{697, 770, 852, 941};
   localparam int unsigned COL_HZ [4]     = '{1209, 1336, 1477, 1633};
   localparam logic [7:0]  KEY_CHARS [16] = '{"1", "2", "3", "A", "4", "5", "6", "B",
                                              "7", "8", "9", "C", "*", "0", "#", "D"};
   localparam int unsigned HORNER_DIV [5] = '{110, 72, 42, 20, 6};
   localparam logic [63:0] Q30_UNIT      = 64'd1073741824;
   localparam logic [63:0] QUARTER_TURN  = 64'd1686629713;

   // Result words that can be read off directly. The first sample of any tone
   // is zero because both phase accumulators start at zero.
   localparam rsp_word_type IDLE_WORD    = '{sample: 16'sd0, status: STATUS_IDLE,    last: 1'b0};
   localparam rsp_word_type BAD_KEY_WORD = '{sample: 16'sd0, status: STATUS_BAD_KEY, last: 1'b0};
   localparam rsp_word_type FIRST_WORD   = '{sample: 16'sd0, status: STATUS_OK,      last: 1'b0};
   localparam rsp_word_type PREDICTED    = '0;

   // One row of the directed sweep. Rows with fixed set carry their expected
   // word; the others are checked against the tone predictor.
   typedef struct packed {
      op_type       op;
      logic [7:0]   key;
      logic         fixed;
      rsp_word_type want;
   } sweep_row;

   // The sweep runs at the reset tone length of 800, so no tone ends in it.
   localparam sweep_row SWEEP [25] = '{
      '{OP_NEXT,  8'h00, 1'b1, IDLE_WORD},     // next while no tone is active
      '{OP_START, 8'h00, 1'b1, BAD_KEY_WORD},  // lowest key code
      '{OP_START, 8'hFF, 1'b1, BAD_KEY_WORD},  // highest key code
      '{OP_START, "E",   1'b1, BAD_KEY_WORD},  // just past the letter keys
      '{OP_START, "1",   1'b1, FIRST_WORD},
      '{OP_NEXT,  8'hFF, 1'b0, PREDICTED},     // key field is ignored on next
      '{OP_NEXT,  8'h5A, 1'b0, PREDICTED},
      '{OP_START, "a",   1'b1, BAD_KEY_WORD},  // bad key must not disturb the tone
      '{OP_NEXT,  8'h00, 1'b0, PREDICTED},
      '{OP_START, "2",   1'b1, FIRST_WORD},    // each start restarts the running tone
      '{OP_START, "3",   1'b1, FIRST_WORD},
      '{OP_START, "A",   1'b1, FIRST_WORD},
      '{OP_START, "4",   1'b1, FIRST_WORD},
      '{OP_START, "5",   1'b1, FIRST_WORD},
      '{OP_START, "6",   1'b1, FIRST_WORD},
      '{OP_START, "B",   1'b1, FIRST_WORD},
      '{OP_START, "7",   1'b1, FIRST_WORD},
      '{OP_START, "8",   1'b1, FIRST_WORD},
      '{OP_START, "9",   1'b1, FIRST_WORD},
      '{OP_START, "C",   1'b1, FIRST_WORD},
      '{OP_START, "*",   1'b1, FIRST_WORD},
      '{OP_START, "0",   1'b1, FIRST_WORD},
      '{OP_START, "#",   1'b1, FIRST_WORD},
      '{OP_START, "D",   1'b1, FIRST_WORD},
      '{OP_NEXT,  8'h80, 1'b0, PREDICTED}
   };

   // Block ports. Every input has a known value from time zero.
   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_valid   = 1'b0;
   logic         req_stall;
   req_word_type req_word    = '0;
   logic         rsp_valid;
   logic         rsp_stall   = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_wr_en   = 1'b0;
   logic [15:0]  csr_wr_data = '0;

   // Predictor state: a private copy of the tone generator.
   int unsigned  quarter_wave [0:DEPTH];
   logic [31:0]  row_phase;
   logic [31:0]  col_phase;
   logic [1:0]   row_sel;
   logic [1:0]   col_sel;
   logic [15:0]  samples_done;
   logic [15:0]  tone_len;
   logic         tone_on;

   // Expected result words, oldest first.
   rsp_word_type tone_words_due [$];

   // Traffic shaping, set by the stimulus process; the result side counts hold_left down.
   int  idle_pct     = 0;
   int  stall_pct    = 0;
   bit  hold_request = 1'b0;
   int  hold_left    = 0;

   // Bookkeeping.
   int  cycle_count     = 0;
   int  errors          = 0;
   int  words_sent      = 0;
   int  samples_checked = 0;
   int  tones_ended     = 0;
   int  length_writes   = 0;
   int  holdoffs        = 0;

   dtmf_tone_generator_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Quarter-wave sine in Q1.15 for angles k/DEPTH of a quarter turn. Each
   // entry comes from a Horner sine series evaluated in unsigned Q30 with every
   // product truncated, then rounded to 15 bits and clamped.
   function automatic void fill_quarter_wave();
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] d;
      logic [63:0] s;
      logic [63:0] v;
      for (int k = 0; k <= DEPTH; k++) begin
         x  = (64'(k) * QUARTER_TURN) / 64'(DEPTH);
         x2 = (x * x) >> 30;
         t  = Q30_UNIT;
         for (int j = 0; j < 5; j++) begin
            d = ((x2 * t) >> 30) / 64'(HORNER_DIV[j]);
            t = (d >= Q30_UNIT) ? 64'd0 : Q30_UNIT - d;
         end
         s = (x * t) >> 30;
         v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
         quarter_wave[k] = (v > 64'd32767) ? 32767 : int'(v);
      end
   endfunction

   // Phase advance per sample: a fraction of a turn in 32 bits, rounded.
   function automatic logic [31:0] tone_step(input int unsigned hz);
      logic [63:0] num;
      num = (64'(hz) << 32) + 64'(RATE / 2);
      num = num / 64'(RATE);
      return num[31:0];
   endfunction

   // Signed sine for a phase: the top two bits give the quadrant, odd quadrants
   // read the table mirrored, the lower half-turn is negated.
   function automatic int sine_at(input logic [31:0] phase);
      logic [63:0] idx;
      int          mag;
      idx = (64'(phase[29:0]) * 64'(DEPTH)) >> 30;
      if (idx > 64'(DEPTH)) begin
         idx = 64'(DEPTH);
      end
      mag = phase[30] ? int'(quarter_wave[DEPTH - int'(idx)]) : int'(quarter_wave[int'(idx)]);
      return phase[31] ? -mag : mag;
   endfunction

   function automatic int key_position(input logic [7:0] key);
      int pos;
      pos = -1;
      for (int i = 0; i < 16; i++) begin
         if (KEY_CHARS[i] == key) begin
            pos = i;
         end
      end
      return pos;
   endfunction

   // Tone predictor: takes one accepted request word, updates the private
   // state and returns the result word the block must produce for it.
   function automatic rsp_word_type next_tone_word(input req_word_type w);
      rsp_word_type r;
      int           pos;
      int           total;
      r = '0;
      r.status = STATUS_OK;
      if (w.op == OP_START) begin
         pos = key_position(w.key);
         if (pos < 0) begin
            r.status = STATUS_BAD_KEY;
            return r;
         end
         row_sel      = 2'(pos >> 2);
         col_sel      = 2'(pos & 3);
         row_phase    = '0;
         col_phase    = '0;
         samples_done = '0;
         tone_on      = 1'b1;
      end else if (!tone_on) begin
         r.status = STATUS_IDLE;
         return r;
      end
      // Half the sum, rounded toward minus infinity.
      total        = sine_at(row_phase) + sine_at(col_phase);
      r.sample     = 16'(total >>> 1);
      row_phase    = row_phase + tone_step(ROW_HZ[row_sel]);
      col_phase    = col_phase + tone_step(COL_HZ[col_sel]);
      samples_done = samples_done + 16'd1;
      // A length of zero, or one lowered below the count, ends the tone here.
      if (samples_done >= tone_len) begin
         r.last  = 1'b1;
         tone_on = 1'b0;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= MAX_PRINTED) begin
         $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      end
   endtask

   // Result side. Stalls follow the current stall rate, except while a long
   // hold-off is running; that hold-off is counted here, cycle by cycle, so
   // the stimulus process can keep offering words meanwhile.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES - 1;
         holdoffs++;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Result checker. A word is taken at an edge where rsp_valid is high and
   // rsp_stall is low; both are sampled as they stood before the edge.
   always @(posedge clock) begin : watch_results
      rsp_word_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (tone_words_due.size() == 0) begin
            report_mismatch($sformatf("result word %h with nothing expected", rsp_word));
         end else begin
            want = tone_words_due.pop_front();
            if (rsp_word.sample !== want.sample) begin
               report_mismatch($sformatf("sample %0d, expected %0d",
                                         rsp_word.sample, want.sample));
            end
            if (rsp_word.status !== want.status) begin
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_word.status, want.status));
            end
            if (rsp_word.last !== want.last) begin
               report_mismatch($sformatf("last %b, expected %b", rsp_word.last, want.last));
            end
            if (want.status == STATUS_OK) begin
               samples_checked++;
            end
            if (want.last) begin
               tones_ended++;
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Offers one word and holds it until the block takes it. The expectation is
   // recorded at the accepting edge. Idle cycles with valid low may follow,
   // each one drawn at the current idle rate.
   task automatic send_word(input req_word_type w, input logic fixed,
                            input rsp_word_type fixed_word);
      rsp_word_type predicted;
      req_word  <= w;
      req_valid <= 1'b1;
      do begin
         @(posedge clock);
      end while (req_stall !== 1'b0);
      predicted = next_tone_word(w);
      tone_words_due.push_back(fixed ? fixed_word : predicted);
      words_sent++;
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_start(input logic [7:0] key);
      req_word_type w;
      w.op  = OP_START;
      w.key = key;
      send_word(w, 1'b0, PREDICTED);
   endtask

   task automatic send_next();
      req_word_type w;
      w.op  = OP_NEXT;
      w.key = 8'($urandom_range(255));
      send_word(w, 1'b0, PREDICTED);
   endtask

   // The sender goes quiet until every expected word has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (tone_words_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Writes tone_length with the block idle, once every expected word has come back.
   task automatic set_tone_length(input logic [15:0] value);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      tone_len = value;
      length_writes++;
      csr_wr_en <= 1'b0;
   endtask

   // Random traffic. Most of it is well-formed: a valid key followed by a run
   // of next words that often runs past the end of the tone. The rest is random
   // key codes, mostly bad, stray next words and the occasional full drain.
   task automatic play_random(input int count);
      int done;
      int choice;
      int run;
      int span;
      done = 0;
      while (done < count) begin
         choice = $urandom_range(99);
         if (choice < 78) begin
            send_start(KEY_CHARS[$urandom_range(15)]);
            span = (int'(tone_len) + 2 > 60) ? 60 : int'(tone_len) + 2;
            run  = $urandom_range(0, span);
            repeat (run) send_next();
            done += run + 1;
         end else if (choice < 90) begin
            send_start(8'($urandom_range(255)));
            done++;
         end else if (choice < 99) begin
            send_next();
            done++;
         end else begin
            wait_drained();
         end
      end
   endtask

   initial begin : stimulus
      int idle_mix [4];
      int stall_mix [4];
      fill_quarter_wave();
      tone_len     = 16'd800;
      tone_on      = 1'b0;
      row_phase    = '0;
      col_phase    = '0;
      row_sel      = '0;
      col_sel      = '0;
      samples_done = '0;
      idle_mix  = '{0, 50, 0, 36};
      stall_mix = '{0, 0, 50, 36};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed sweep at the reset length: every key, bad keys at both ends
      // of the code range, next with no tone, and restarts of a running tone.
      foreach (SWEEP[i]) begin
         send_word('{op: SWEEP[i].op, key: SWEEP[i].key}, SWEEP[i].fixed, SWEEP[i].want);
      end

      // Length extremes. With a length of one or zero, every start is also the
      // final sample, and the next word finds the block idle.
      set_tone_length(16'd1);
      send_start("5");
      send_next();
      send_start("#");
      set_tone_length(16'd0);
      send_start("D");
      send_start("*");
      send_next();
      set_tone_length(16'hFFFF);
      send_start("9");
      repeat (30) send_next();

      // Lowering the length under the running count ends the tone on the very
      // next sample.
      set_tone_length(16'd800);
      send_start("C");
      repeat (20) send_next();
      set_tone_length(16'd5);
      send_next();
      send_next();

      // Random traffic under each idle/stall mix, with a fresh length for each full
      // chunk: short tones, middling ones, and ones longer than any run.
      for (int m = 0; m < 4; m++) begin
         idle_pct  = idle_mix[m];
         stall_pct = stall_mix[m];
         set_tone_length(16'($urandom_range(1, 8)));
         play_random(CHUNK_WORDS);
         set_tone_length(16'($urandom_range(1, 40)));
         play_random(CHUNK_WORDS);
         wait_drained();
         play_random(CHUNK_WORDS / 5);
         set_tone_length(16'($urandom_range(100, 300)));
         play_random(CHUNK_WORDS);
      end

      // Back-pressure: the result side holds off for a long stretch while the
      // sender keeps offering words, so the skid register fills and the block
      // stalls its input.
      idle_pct  = 0;
      stall_pct = 0;
      set_tone_length(16'($urandom_range(3, 12)));
      hold_request = 1'b1;
      play_random(60);

      wait_drained();
      repeat (8) @(posedge clock);

      if (tone_words_due.size() != 0) begin
         report_mismatch($sformatf("%0d result words never arrived", tone_words_due.size()));
      end
      $display("Sent %0d request words over %0d tone length settings, four idle/stall mixes",
               words_sent, length_writes);
      $display("and %0d long result hold-off(s); %0d samples compared, %0d tones ran out.",
               holdoffs, samples_checked, tones_ended);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
